// File: src/lce_pkg.sv
// Package for the LSTM cell element pipeline: request/response structs,
// activation codes, Q3.12 helpers and the sigmoid table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lce_pkg;

   localparam int DataWidth  = 16;
   localparam int FracBits   = 12;
   localparam int SigEntries = 256;
   localparam int SigIdxBits = $clog2(SigEntries);

   localparam logic [1:0] ACT_SIGMOID  = 2'd0;
   localparam logic [1:0] ACT_RELU     = 2'd1;
   localparam logic [1:0] ACT_TANH     = 2'd2;
   localparam logic [1:0] ACT_IDENTITY = 2'd3;

   localparam logic [1:0] CSR_USE_PEEPHOLE = 2'd0;
   localparam logic [1:0] CSR_GATE_ACT     = 2'd1;
   localparam logic [1:0] CSR_CAND_ACT     = 2'd2;
   localparam logic [1:0] CSR_CELL_ACT     = 2'd3;

   typedef logic signed [DataWidth-1:0] data_type;

   typedef struct packed {
      logic     operation;
      data_type cand_pre;
      data_type in_pre;
      data_type forget_pre;
      data_type out_pre;
      data_type cell_prev;
      data_type peep_in;
      data_type peep_forget;
      data_type peep_out;
      logic     last_in;
   } req_type;

   typedef struct packed {
      data_type cell_out;
      data_type hidden_out;
      logic     last_out;
   } rsp_type;

   typedef data_type sig_rom_type [SigEntries];

   localparam longint DMax = (longint'(1) <<< (DataWidth - 1)) - 1;
   localparam longint DMin = -(longint'(1) <<< (DataWidth - 1));

   // shift-subtract division, only evaluated while the table is built
   function automatic longint unsigned udiv(input longint unsigned a,
                                            input longint unsigned b);
      longint unsigned quo;
      logic [64:0]     rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], a[i]};
         if (rem >= {1'b0, b}) begin
            rem    = rem - {1'b0, b};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // table entry k: sigmoid of the bucket centre, series exp in Q32
   function automatic data_type rom_entry(input int k);
      longint unsigned num, m, e, t, d, den, q, tq;
      longint          c, r;
      logic            done;
      num  = longint'(2 * k + 1) << DataWidth;
      c    = longint'(num >> (SigIdxBits + 1)) - (longint'(1) <<< (DataWidth - 1));
      m    = (c < 0) ? longint'(-c) : longint'(c);
      if (m > (longint'(16) << FracBits)) m = longint'(16) << FracBits;
      e    = longint'(1) << 32;
      t    = longint'(1) << 32;
      done = 1'b0;
      for (int n = 1; n <= 120; n++) begin
         if (!done) begin
            d  = longint'(n) << FracBits;
            tq = udiv(t, d);
            t  = tq * m + udiv((t - tq * d) * m, d);
            if (t == 0) done = 1'b1;
            else e = e + t;
         end
      end
      den = e + (longint'(1) << 32);
      q   = udiv((longint'(1) << (FracBits + 32)) + (den >> 1), den);
      r   = (c < 0) ? longint'(q) : (longint'(1) <<< FracBits) - longint'(q);
      if (r > DMax) r = DMax;
      return data_type'(r);
   endfunction

   function automatic sig_rom_type build_rom();
      sig_rom_type rom;
      for (int k = 0; k < SigEntries; k++) rom[k] = rom_entry(k);
      return rom;
   endfunction

   localparam sig_rom_type SigRom = build_rom();

   function automatic data_type sat17(input logic signed [DataWidth:0] v);
      if (v > (DataWidth+1)'(DMax)) return data_type'(DMax);
      if (v < (DataWidth+1)'(DMin)) return data_type'(DMin);
      return data_type'(v);
   endfunction

   // round-half-up product finish: (p + half) >>> frac, saturated
   function automatic data_type qfin(input logic signed [2*DataWidth-1:0] p);
      logic signed [2*DataWidth:0]          s;
      logic signed [2*DataWidth-FracBits:0] sh;
      s  = (2*DataWidth+1)'(p) + (2*DataWidth+1)'(longint'(1) <<< (FracBits - 1));
      sh = (2*DataWidth-FracBits+1)'(s >>> FracBits);
      if (sh > (2*DataWidth-FracBits+1)'(DMax)) return data_type'(DMax);
      if (sh < (2*DataWidth-FracBits+1)'(DMin)) return data_type'(DMin);
      return data_type'(sh);
   endfunction

   function automatic data_type sig_lookup(input data_type x);
      logic [SigIdxBits-1:0] idx;
      idx = {~x[DataWidth-1], x[DataWidth-2 -: SigIdxBits-1]};
      return SigRom[idx];
   endfunction

   function automatic data_type act_apply(input logic [1:0] sel, input data_type x);
      data_type s;
      case (sel)
         ACT_SIGMOID:  return sig_lookup(x);
         ACT_RELU:     return x[DataWidth-1] ? '0 : x;
         ACT_TANH: begin
            s = sig_lookup(sat17({x[DataWidth-1], x} <<< 1));
            return sat17(({s[DataWidth-1], s} <<< 1)
                         - (DataWidth+1)'(longint'(1) <<< FracBits));
         end
         default:      return x;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: src/lstm_cell_elementwise.sv
// LSTM cell element pipeline, top level. Uses lce_pkg for types,
// Q3.12 helpers and the sigmoid table.
//
//  channel   ports                               direction
//  request   start, busy, req_data               in (busy always low)
//  response  rsp_valid, rsp_data                 out, one-cycle strobe
//  config    csr_we, csr_index, csr_wdata        in, write only
//
// One request per cycle; each response passes through every pipeline register before it leaves.
// The latency is set by the dependent multiply chain: peephole products,
// gate activations, cell products, output peephole, hidden product.
// Synchronous reset clears the valid bits and the CSRs; the data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none
module lstm_cell_elementwise (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lce_pkg::req_type req_data,
   output logic                  rsp_valid,
   output lce_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [1:0]       csr_wdata
);
   import lce_pkg::*;

   localparam int Stages = 10;
   localparam int PW = 2 * DataWidth;

   logic       peep_ff;
   logic [1:0] gact_ff, cact_ff, lact_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peep_ff <= 1'b0;
         gact_ff <= ACT_SIGMOID;
         cact_ff <= ACT_TANH;
         lact_ff <= ACT_TANH;
      end else if (csr_we) begin
         case (csr_index)
            CSR_USE_PEEPHOLE: peep_ff <= csr_wdata[0];
            CSR_GATE_ACT:     gact_ff <= csr_wdata;
            CSR_CAND_ACT:     cact_ff <= csr_wdata;
            CSR_CELL_ACT:     lact_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;
   assign vld_in = {vld_ff[Stages-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   // stage 1: request capture and input/forget peephole products
   data_type            s1_cand_ff, s1_ipre_ff, s1_fpre_ff, s1_opre_ff, s1_cp_ff, s1_wo_ff;
   logic signed [PW-1:0] s1_pi_ff, s1_pf_ff;
   logic                s1_last_ff;
   data_type            cp_in;
   assign cp_in = req_data.operation ? '0 : req_data.cell_prev;

   always_ff @(posedge clock) begin
      s1_cand_ff <= req_data.cand_pre;
      s1_ipre_ff <= req_data.in_pre;
      s1_fpre_ff <= req_data.forget_pre;
      s1_opre_ff <= req_data.out_pre;
      s1_cp_ff   <= cp_in;
      s1_wo_ff   <= req_data.peep_out;
      s1_last_ff <= req_data.last_in;
      s1_pi_ff   <= req_data.peep_in * cp_in;
      s1_pf_ff   <= req_data.peep_forget * cp_in;
   end

   // stage 2: peephole sums
   data_type s2_cand_ff, s2_ipre_ff, s2_fpre_ff, s2_opre_ff, s2_cp_ff, s2_wo_ff;
   logic     s2_last_ff;
   data_type ipre_in, fpre_in, rpi, rpf;
   assign rpi = qfin(s1_pi_ff);
   assign rpf = qfin(s1_pf_ff);
   assign ipre_in = peep_ff ? sat17({s1_ipre_ff[DataWidth-1], s1_ipre_ff}
                       + {rpi[DataWidth-1], rpi}) : s1_ipre_ff;
   assign fpre_in = peep_ff ? sat17({s1_fpre_ff[DataWidth-1], s1_fpre_ff}
                       + {rpf[DataWidth-1], rpf}) : s1_fpre_ff;

   always_ff @(posedge clock) begin
      s2_cand_ff <= s1_cand_ff;
      s2_ipre_ff <= ipre_in;
      s2_fpre_ff <= fpre_in;
      s2_opre_ff <= s1_opre_ff;
      s2_cp_ff   <= s1_cp_ff;
      s2_wo_ff   <= s1_wo_ff;
      s2_last_ff <= s1_last_ff;
   end

   // stage 3: gate and candidate activations
   data_type s3_ig_ff, s3_fg_ff, s3_cg_ff, s3_opre_ff, s3_cp_ff, s3_wo_ff;
   logic     s3_last_ff;

   always_ff @(posedge clock) begin
      s3_ig_ff   <= act_apply(gact_ff, s2_ipre_ff);
      s3_fg_ff   <= act_apply(gact_ff, s2_fpre_ff);
      s3_cg_ff   <= act_apply(cact_ff, s2_cand_ff);
      s3_opre_ff <= s2_opre_ff;
      s3_cp_ff   <= s2_cp_ff;
      s3_wo_ff   <= s2_wo_ff;
      s3_last_ff <= s2_last_ff;
   end

   // stage 4: cell products
   logic signed [PW-1:0] s4_pgi_ff, s4_pcf_ff;
   data_type             s4_opre_ff, s4_wo_ff;
   logic                 s4_last_ff;

   always_ff @(posedge clock) begin
      s4_pgi_ff  <= s3_cg_ff * s3_ig_ff;
      s4_pcf_ff  <= s3_cp_ff * s3_fg_ff;
      s4_opre_ff <= s3_opre_ff;
      s4_wo_ff   <= s3_wo_ff;
      s4_last_ff <= s3_last_ff;
   end

   // stage 5: new cell value
   data_type s5_c_ff, s5_opre_ff, s5_wo_ff;
   logic     s5_last_ff;
   data_type rgi, rcf;
   assign rgi = qfin(s4_pgi_ff);
   assign rcf = qfin(s4_pcf_ff);

   always_ff @(posedge clock) begin
      s5_c_ff    <= sat17({rgi[DataWidth-1], rgi} + {rcf[DataWidth-1], rcf});
      s5_opre_ff <= s4_opre_ff;
      s5_wo_ff   <= s4_wo_ff;
      s5_last_ff <= s4_last_ff;
   end

   // stage 6: output peephole product
   logic signed [PW-1:0] s6_po_ff;
   data_type             s6_c_ff, s6_opre_ff;
   logic                 s6_last_ff;

   always_ff @(posedge clock) begin
      s6_po_ff   <= s5_wo_ff * s5_c_ff;
      s6_c_ff    <= s5_c_ff;
      s6_opre_ff <= s5_opre_ff;
      s6_last_ff <= s5_last_ff;
   end

   // stage 7: output gate sum
   data_type s7_c_ff, s7_opre_ff;
   logic     s7_last_ff;
   data_type rpo;
   assign rpo = qfin(s6_po_ff);

   always_ff @(posedge clock) begin
      s7_opre_ff <= peep_ff ? sat17({s6_opre_ff[DataWidth-1], s6_opre_ff}
                                    + {rpo[DataWidth-1], rpo}) : s6_opre_ff;
      s7_c_ff    <= s6_c_ff;
      s7_last_ff <= s6_last_ff;
   end

   // stage 8: output gate and cell activations
   data_type s8_c_ff, s8_og_ff, s8_lc_ff;
   logic     s8_last_ff;

   always_ff @(posedge clock) begin
      s8_og_ff   <= act_apply(gact_ff, s7_opre_ff);
      s8_lc_ff   <= act_apply(lact_ff, s7_c_ff);
      s8_c_ff    <= s7_c_ff;
      s8_last_ff <= s7_last_ff;
   end

   // stage 9: hidden product
   logic signed [PW-1:0] s9_ph_ff;
   data_type             s9_c_ff;
   logic                 s9_last_ff;

   always_ff @(posedge clock) begin
      s9_ph_ff   <= s8_lc_ff * s8_og_ff;
      s9_c_ff    <= s8_c_ff;
      s9_last_ff <= s8_last_ff;
   end

   // stage 10: response register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff.cell_out   <= s9_c_ff;
      rsp_ff.hidden_out <= qfin(s9_ph_ff);
      rsp_ff.last_out   <= s9_last_ff;
   end

   assign rsp_valid = vld_ff[Stages-1];
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: tb/sv/lce_checker.sv
// Checker for the LSTM cell element pipeline: mirrors the CSRs, predicts
// cell and hidden outputs per request and compares responses. Uses lce_pkg.
`timescale 1ns / 1ps
module lce_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  lce_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  lce_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [1:0]       csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               rsp_seen
);
   import lce_pkg::*;

   localparam longint QOne = longint'(1) <<< FracBits;

   logic       peep_en;
   logic [1:0] gate_sel, cand_sel, cell_sel;
   longint     sig_table [SigEntries];
   rsp_type    expected_q [$];

   function automatic longint clamp_d(longint v);
      if (v > DMax) return DMax;
      if (v < DMin) return DMin;
      return v;
   endfunction

   // round half up, floor shift, saturate
   function automatic longint fx_mul(longint a, longint b);
      return clamp_d((a * b + (longint'(1) <<< (FracBits - 1))) >>> FracBits);
   endfunction

   function automatic longint sig_entry(int k);
      longint unsigned num, m, e, t, d, den, q;
      longint          c;
      num = longint'(2 * k + 1) << DataWidth;
      c   = longint'(num / (2 * SigEntries)) - (longint'(1) <<< (DataWidth - 1));
      m   = (c < 0) ? -c : c;
      if (m > (longint'(16) << FracBits)) m = longint'(16) << FracBits;
      e = longint'(1) << 32;
      t = e;
      for (int n = 1; n <= 120; n++) begin
         d = longint'(n) << FracBits;
         t = (t / d) * m + ((t % d) * m) / d;
         if (t == 0) break;
         e += t;
      end
      den = e + (longint'(1) << 32);
      q   = ((longint'(1) << (FracBits + 32)) + den / 2) / den;
      return clamp_d((c < 0) ? longint'(q) : QOne - longint'(q));
   endfunction

   function automatic longint sigmoid(longint x);
      return sig_table[((x - DMin) * SigEntries) >>> DataWidth];
   endfunction

   function automatic longint activate(logic [1:0] sel, longint x);
      case (sel)
         ACT_SIGMOID: return sigmoid(x);
         ACT_RELU:    return (x < 0) ? 0 : x;
         ACT_TANH:    return clamp_d(2 * sigmoid(clamp_d(2 * x)) - QOne);
         default:     return x;
      endcase
   endfunction

   function automatic rsp_type lstm_step(req_type r);
      longint  cp, ip, fp, op, ig, fg, cg, c, h;
      rsp_type o;
      cp = r.operation ? 0 : longint'(r.cell_prev);
      ip = r.in_pre;
      fp = r.forget_pre;
      op = r.out_pre;
      if (peep_en) begin
         ip = clamp_d(ip + fx_mul(r.peep_in, cp));
         fp = clamp_d(fp + fx_mul(r.peep_forget, cp));
      end
      ig = activate(gate_sel, ip);
      fg = activate(gate_sel, fp);
      cg = activate(cand_sel, r.cand_pre);
      c  = clamp_d(fx_mul(cg, ig) + fx_mul(cp, fg));
      if (peep_en) op = clamp_d(op + fx_mul(r.peep_out, c));
      h  = fx_mul(activate(cell_sel, c), activate(gate_sel, op));
      o.cell_out   = data_type'(c);
      o.hidden_out = data_type'(h);
      o.last_out   = r.last_in;
      return o;
   endfunction

   initial for (int k = 0; k < SigEntries; k++) sig_table[k] = sig_entry(k);

   assign pending = expected_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         peep_en  <= 1'b0;
         gate_sel <= ACT_SIGMOID;
         cand_sel <= ACT_TANH;
         cell_sel <= ACT_TANH;
         fail_count <= 0;
         rsp_seen   <= 0;
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_q.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.cell_out !== want.cell_out ||
                   rsp_data.hidden_out !== want.hidden_out ||
                   rsp_data.last_out !== want.last_out)
                  fail_count <= fail_count + 1;
               if (rsp_data.cell_out !== want.cell_out)
                  $error("cell_out: expected %0d, got %0d", want.cell_out,
                         rsp_data.cell_out);
               if (rsp_data.hidden_out !== want.hidden_out)
                  $error("hidden_out: expected %0d, got %0d", want.hidden_out,
                         rsp_data.hidden_out);
               if (rsp_data.last_out !== want.last_out)
                  $error("last_out: expected %0d, got %0d", want.last_out,
                         rsp_data.last_out);
            end
         end
         if (start && !busy) expected_q.push_back(lstm_step(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_USE_PEEPHOLE: peep_en  <= csr_wdata[0];
               CSR_GATE_ACT:     gate_sel <= csr_wdata;
               CSR_CAND_ACT:     cand_sel <= csr_wdata;
               default:          cell_sel <= csr_wdata;
            endcase
         end
      end
   end
endmodule

// File: tb/sv/lstm_cell_elementwise_tb.sv
// Testbench top for lstm_cell_elementwise: clock, reset, CSR phases and
// request stimulus. Checking lives in lce_checker; uses lce_pkg.
`timescale 1ns / 1ps
module lstm_cell_elementwise_tb;
   import lce_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int Latency    = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [1:0] csr_wdata = '0;
   int fail_count, pending, rsp_seen;
   int cycles = 0;
   int n_items = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   lstm_cell_elementwise u_dut (.*);

   lce_checker u_chk (.*);

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3, 4: return data_type'($urandom_range(0, 16384) - 8192);
         default: return data_type'($urandom);
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      r = '0;
      r.cand_pre    = pick_value();
      r.in_pre      = pick_value();
      r.forget_pre  = pick_value();
      r.out_pre     = pick_value();
      r.cell_prev   = pick_value();
      r.peep_in     = pick_value();
      r.peep_forget = pick_value();
      r.peep_out    = pick_value();
      r.operation   = ($urandom_range(0, 4) == 0);
      r.last_in     = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic send_req(req_type r, bit gaps);
      while (gaps && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_items++;
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [1:0] val);
      start     <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (Latency + 2) @(negedge clock);
   endtask

   task automatic set_mode(logic peep, logic [1:0] g, logic [1:0] c, logic [1:0] l);
      drain();
      write_csr(CSR_USE_PEEPHOLE, {1'b0, peep});
      write_csr(CSR_GATE_ACT, g);
      write_csr(CSR_CAND_ACT, c);
      write_csr(CSR_CELL_ACT, l);
   endtask

   initial begin
      req_type r;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, both operations, reset settings then peepholes
      for (int i = 0; i < 12; i++) begin
         r = '0;
         {r.cand_pre, r.in_pre, r.forget_pre, r.out_pre} =
            {4{(i[0]) ? 16'sh7fff : 16'sh8000}};
         r.cell_prev = (i[1]) ? 16'sh7fff : 16'sh8000;
         {r.peep_in, r.peep_forget, r.peep_out} = {3{(i[2]) ? 16'sh7fff : 16'sh8000}};
         r.operation = i[3];
         r.last_in   = i[0] ^ i[1];
         send_req(r, 1'b0);
      end
      set_mode(1'b1, ACT_SIGMOID, ACT_TANH, ACT_TANH);
      for (int i = 0; i < 12; i++) send_req(random_req(), 1'b0);

      // random phases over identity, ReLU/sigmoid and random activation settings, extremes included
      for (int ph = 0; ph < 24; ph++) begin
         if (ph == 0) set_mode(1'b0, ACT_IDENTITY, ACT_IDENTITY, ACT_IDENTITY);
         else if (ph == 1) set_mode(1'b1, ACT_RELU, ACT_SIGMOID, ACT_RELU);
         else set_mode(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         for (int i = 0; i < 47; i++) send_req(random_req(), ph % 6 != 3);
      end
      drain();

      $display("Covered %0d requests, %0d responses over 26 CSR settings.",
               n_items, rsp_seen);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
